// File: rtl/core/swpr_pkg.sv
// package: sizes, types and codes shared by the sliding window peak rate block
`default_nettype none

package swpr_pkg;

    localparam int FIFO_DEPTH = 1024;
    localparam int STAMP_BITS = 32;
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_BITS   = (STAMP_BITS > 32) ? STAMP_BITS : 32;

    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 3;

    localparam int COUNT_FIELD_BITS = 11;
    localparam int TIME_FIELD_BITS  = 32;

    localparam logic [ADDR_BITS-1:0] ADDR_WINDOW_ENABLE  = 3'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_WINDOW_SECONDS = 3'd4;

    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic   push;
        logic   shift;
        cnt_t   wr_idx;
        stamp_t data;
    } chain_ctrl_t;

    typedef struct packed {
        logic [COUNT_FIELD_BITS-1:0] window_count;
        logic [COUNT_FIELD_BITS-1:0] peak_count;
        logic [TIME_FIELD_BITS-1:0]  peak_first;
        logic [TIME_FIELD_BITS-1:0]  peak_last;
        logic                        overflow;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/swpr_cell.sv
// one stamp cell of the queue chain: load, shift from upper neighbor or hold
`default_nettype none

module swpr_cell (
    input  wire                  aclk,
    input  wire                  load_en,
    input  wire                  shift_en,
    input  swpr_pkg::stamp_t     load_data,
    input  swpr_pkg::stamp_t     shift_in,
    output swpr_pkg::stamp_t     q
);

    swpr_pkg::stamp_t stamp_reg;
    swpr_pkg::stamp_t stamp_next;

    always_comb begin
        priority if (load_en) begin
            stamp_next = load_data;
        end else if (shift_en) begin
            stamp_next = shift_in;
        end else begin
            stamp_next = stamp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg <= stamp_next;
    end

    assign q = stamp_reg;

endmodule

`default_nettype wire

// File: rtl/core/swpr_chain.sv
// row of stamp cells, oldest stamp at cell zero, shifting toward it on pop
`default_nettype none

module swpr_chain (
    input  wire                    aclk,
    input  swpr_pkg::chain_ctrl_t  ctrl,
    output swpr_pkg::stamp_t       head,
    output swpr_pkg::stamp_t       second
);

    swpr_pkg::stamp_t cell_q [swpr_pkg::FIFO_DEPTH];

    genvar i;
    generate
        for (i = 0; i < swpr_pkg::FIFO_DEPTH; i++) begin : g_cell
            swpr_pkg::stamp_t upper;
            logic             load_en;

            if (i == swpr_pkg::FIFO_DEPTH - 1) begin : g_top
                assign upper = cell_q[i];
            end else begin : g_mid
                assign upper = cell_q[i+1];
            end

            assign load_en = ctrl.push && (ctrl.wr_idx == swpr_pkg::cnt_t'(i));

            swpr_cell u_cell (
                .aclk      (aclk),
                .load_en   (load_en),
                .shift_en  (ctrl.shift),
                .load_data (ctrl.data),
                .shift_in  (upper),
                .q         (cell_q[i])
            );
        end
    endgenerate

    assign head   = cell_q[0];
    assign second = cell_q[1];

endmodule

`default_nettype wire

// File: rtl/core/swpr_ctrl.sv
// sequencer: window check, pop loop, append, peak tracking and result register
`default_nettype none

module swpr_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  swpr_pkg::stamp_t       start_stamp,
    input  wire                    window_enable,
    input  wire [31:0]             window_seconds,
    input  swpr_pkg::stamp_t       head,
    input  swpr_pkg::stamp_t       second,
    input  wire                    out_ready,
    output swpr_pkg::chain_ctrl_t  chain_ctrl,
    output logic                   busy,
    output logic                   out_valid,
    output swpr_pkg::result_t      result
);

    swpr_pkg::seq_state_t state_reg, state_next;

    swpr_pkg::stamp_t  stamp_reg;
    swpr_pkg::cnt_t    count_reg, count_next;
    swpr_pkg::cnt_t    best_count_reg, best_count_next;
    swpr_pkg::stamp_t  best_first_reg, best_first_next;
    swpr_pkg::stamp_t  best_last_reg, best_last_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    swpr_pkg::result_t result_reg;

    logic [swpr_pkg::STAMP_BITS:0] diff;
    logic in_win, empty, full, hit, out_free;
    logic do_pop, do_push, upd_peak, finish;

    assign diff     = {1'b0, stamp_reg} - {1'b0, head};
    assign in_win   = diff[swpr_pkg::STAMP_BITS]
                      || (swpr_pkg::cmp_t'(diff[swpr_pkg::STAMP_BITS-1:0])
                          < swpr_pkg::cmp_t'(window_seconds));
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == swpr_pkg::cnt_t'(swpr_pkg::FIFO_DEPTH));
    assign hit      = empty || in_win;
    assign out_free = !out_valid_reg || out_ready;

    // actions of the current state
    always_comb begin
        do_pop   = 1'b0;
        do_push  = 1'b0;
        upd_peak = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            swpr_pkg::ST_IDLE: begin
            end
            swpr_pkg::ST_CHECK: begin
                priority if (!window_enable) begin
                    finish = out_free;
                end else if (hit) begin
                    do_push  = out_free;
                    upd_peak = out_free;
                    finish   = out_free;
                end else begin
                    do_pop = 1'b1;
                end
            end
            swpr_pkg::ST_DRAIN: begin
                if (hit) begin
                    do_push = out_free;
                    finish  = out_free;
                end else begin
                    do_pop = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swpr_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = swpr_pkg::ST_CHECK;
                end
            end
            swpr_pkg::ST_CHECK: begin
                priority if (finish) begin
                    state_next = swpr_pkg::ST_IDLE;
                end else if (do_pop) begin
                    state_next = swpr_pkg::ST_DRAIN;
                end
            end
            swpr_pkg::ST_DRAIN: begin
                if (finish) begin
                    state_next = swpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swpr_pkg::ST_IDLE;
            end
        endcase
    end

    // queue and peak updates
    always_comb begin
        chain_ctrl.push   = do_push;
        chain_ctrl.shift  = do_pop || (do_push && full);
        chain_ctrl.wr_idx = (do_push && full) ? count_reg - swpr_pkg::cnt_t'(1) : count_reg;
        chain_ctrl.data   = stamp_reg;

        priority if (do_pop) begin
            count_next = count_reg - swpr_pkg::cnt_t'(1);
        end else if (do_push && !full) begin
            count_next = count_reg + swpr_pkg::cnt_t'(1);
        end else begin
            count_next = count_reg;
        end

        ovf_next        = ovf_reg || (do_push && full);
        best_count_next = best_count_reg;
        best_first_next = best_first_reg;
        best_last_next  = best_last_reg;
        if (upd_peak && (count_next > best_count_reg)) begin
            best_count_next = count_next;
            best_last_next  = stamp_reg;
            priority if (empty) begin
                best_first_next = stamp_reg;
            end else if (full) begin
                best_first_next = second;
            end else begin
                best_first_next = head;
            end
        end

        out_valid_next = finish || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= swpr_pkg::ST_IDLE;
            count_reg      <= '0;
            best_count_reg <= '0;
            best_first_reg <= '0;
            best_last_reg  <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            best_count_reg <= best_count_next;
            best_first_reg <= best_first_next;
            best_last_reg  <= best_last_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            stamp_reg <= start_stamp;
        end
        if (finish) begin
            result_reg.window_count <= 11'(count_next);
            result_reg.peak_count   <= 11'(best_count_next);
            result_reg.peak_first   <= 32'(best_first_next);
            result_reg.peak_last    <= 32'(best_last_next);
            result_reg.overflow     <= ovf_next;
        end
    end

    assign busy      = (state_reg != swpr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_peak_rate.sv
// top level: config registers, stream ports, sequencer and stamp cell chain
// with the window enabled, an item is taken in and checked; stamps outside the window
// are popped one at a time, then the item is appended once the output register is free;
// each stamp is popped at most once, and only one item is in work at a time
// a finished result waits in an output register while the next item is taken
// reset clears control, counts, peak and flags at once; stamp cells have no reset
`default_nettype none

module sliding_window_peak_rate (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [swpr_pkg::ADDR_BITS-1:0]    paddr,
    input  wire [swpr_pkg::DATA_BITS-1:0]    pwdata,
    output logic [swpr_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [31:0]                       s_tdata,   // event_time
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // window_count[10:0], peak_count[21:11], peak_first[53:22], peak_last[85:54],
    // overflow[86], zero[87]
    output logic [87:0]                      m_tdata
);

    logic        window_enable_reg;
    logic [31:0] window_seconds_reg;
    logic        wr_en;

    swpr_pkg::chain_ctrl_t chain_ctrl;
    swpr_pkg::stamp_t      head, second;
    swpr_pkg::result_t     result;
    logic                  busy, start;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_enable_reg  <= 1'b0;
            window_seconds_reg <= '0;
        end else if (wr_en) begin
            if (paddr == swpr_pkg::ADDR_WINDOW_ENABLE) begin
                window_enable_reg <= pwdata[0];
            end
            if (paddr == swpr_pkg::ADDR_WINDOW_SECONDS) begin
                window_seconds_reg <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == swpr_pkg::ADDR_WINDOW_ENABLE) begin
            prdata = {31'b0, window_enable_reg};
        end else if (paddr == swpr_pkg::ADDR_WINDOW_SECONDS) begin
            prdata = window_seconds_reg;
        end
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    swpr_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (start),
        .start_stamp    (swpr_pkg::stamp_t'(s_tdata)),
        .window_enable  (window_enable_reg),
        .window_seconds (window_seconds_reg),
        .head           (head),
        .second         (second),
        .out_ready      (m_tready),
        .chain_ctrl     (chain_ctrl),
        .busy           (busy),
        .out_valid      (m_tvalid),
        .result         (result)
    );

    swpr_chain u_chain (
        .aclk   (aclk),
        .ctrl   (chain_ctrl),
        .head   (head),
        .second (second)
    );

    assign m_tdata = {1'b0, result.overflow, result.peak_last, result.peak_first,
                      result.peak_count, result.window_count};

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:0] <= m_tdata[21:11]))
        else $error("window count above peak count");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tdata[86]) |=> (!m_tvalid || m_tdata[86]))
        else $error("overflow flag cleared");

endmodule

`default_nettype wire
